>>> rtl/core/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types, constants and helpers of the Huffman codebook bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int TABLE_ENTRIES_DEF   = 256;
  localparam int MAX_PATCH_WORDS_DEF = 4;

  localparam int WORD_BITS = 64;
  localparam int LEN_W     = 7;
  localparam int KEY_W     = 32;
  localparam int ENTRY_W   = 8;
  localparam int PLEN_W    = 3;

  // Item modes.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // Request from the sequencer to the packer.
  typedef struct packed {
    logic                 append;
    logic                 flush;
    logic [WORD_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
  } pack_req_t;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= LEN_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

>>> rtl/core/hcbp_table.sv
// ----------------------------------------------------------------------------
// hcbp_table
// Codebook memory: one row per entry holding the patch words, the code and
// its length, with one registered read port and per-entry valid
// flags that reset clears.
// ----------------------------------------------------------------------------
module hcbp_table #(
  parameter int ENTRIES         = hcbp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_PATCH_WORDS = hcbp_pkg::MAX_PATCH_WORDS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        wr_en,
  input  logic [$clog2(ENTRIES)-1:0]                  wr_addr,
  input  logic [MAX_PATCH_WORDS*hcbp_pkg::KEY_W-1:0]  wr_keys,
  input  logic [hcbp_pkg::WORD_BITS-1:0]              wr_code,
  input  logic [hcbp_pkg::LEN_W-1:0]                  wr_len,
  input  logic [$clog2(ENTRIES)-1:0]                  rd_addr,
  output logic                                        rd_valid,
  output logic [MAX_PATCH_WORDS*hcbp_pkg::KEY_W-1:0]  rd_keys,
  output logic [hcbp_pkg::WORD_BITS-1:0]              rd_code,
  output logic [hcbp_pkg::LEN_W-1:0]                  rd_len
);
  import hcbp_pkg::*;

  localparam int KEYS_W = MAX_PATCH_WORDS * KEY_W;
  localparam int ROW_W  = KEYS_W + WORD_BITS + LEN_W;

  logic [ROW_W-1:0]   mem [ENTRIES];
  logic [ROW_W-1:0]   rd_row_r;
  logic [ENTRIES-1:0] valid_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_code, wr_keys};
    end
    rd_row_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_keys  = rd_row_r[KEYS_W-1:0];
  assign rd_code  = rd_row_r[KEYS_W +: WORD_BITS];
  assign rd_len   = rd_row_r[KEYS_W+WORD_BITS +: LEN_W];

endmodule

>>> rtl/core/hcbp_packer.sv
// ----------------------------------------------------------------------------
// hcbp_packer
// Appends codes MSB-first to the pending 64-bit word and registers each
// word that fills or that a flush releases.
// ----------------------------------------------------------------------------
module hcbp_packer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hcbp_pkg::pack_req_t            req,
  output logic                           out_valid,
  output logic [hcbp_pkg::WORD_BITS-1:0] out_packed_word,
  output logic [hcbp_pkg::LEN_W-1:0]     out_bits_used,
  output logic                           out_last
);
  import hcbp_pkg::*;

  logic [WORD_BITS-1:0] pend_word_r, pend_word_nxt;
  logic [LEN_W-1:0]     pend_bits_r, pend_bits_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_word_r, out_word_nxt;
  logic [LEN_W-1:0]     out_bits_r, out_bits_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [LEN_W-1:0]     space;
  logic [LEN_W-1:0]     rest;
  logic [WORD_BITS-1:0] code_shl;
  logic [WORD_BITS-1:0] code_shr;
  logic [WORD_BITS-1:0] spill;

  always_comb begin
    space    = LEN_W'(WORD_BITS) - pend_bits_r;
    rest     = req.len - space;
    code_shl = req.code << (space - req.len);
    code_shr = req.code >> rest;
    // Only the low rest bits survive this shift, so no extra mask is needed.
    spill    = req.code << (LEN_W'(WORD_BITS) - rest);
  end

  always_comb begin
    pend_word_nxt = pend_word_r;
    pend_bits_nxt = pend_bits_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;
    if (req.flush) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = pend_word_r;
      out_bits_nxt  = pend_bits_r;
      out_last_nxt  = 1'b1;
      pend_word_nxt = '0;
      pend_bits_nxt = '0;
    end else if (req.append && (req.len != '0)) begin
      if (req.len < space) begin
        pend_word_nxt = pend_word_r | code_shl;
        pend_bits_nxt = pend_bits_r + req.len;
      end else if (req.len == space) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = pend_word_r | req.code;
        out_bits_nxt  = LEN_W'(WORD_BITS);
        out_last_nxt  = 1'b0;
        pend_word_nxt = '0;
        pend_bits_nxt = '0;
      end else begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = pend_word_r | code_shr;
        out_bits_nxt  = LEN_W'(WORD_BITS);
        out_last_nxt  = 1'b0;
        pend_word_nxt = spill;
        pend_bits_nxt = rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_word_r <= '0;
      pend_bits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_word_r <= pend_word_nxt;
      pend_bits_r <= pend_bits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packed_word = out_word_r;
  assign out_bits_used   = out_bits_r;
  assign out_last        = out_last_r;

endmodule

>>> rtl/core/huffman_codebook_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_codebook_bit_packer
// Huffman encoder with a loaded codebook: searches the table for a symbol
// and packs its code MSB-first into 64-bit output words.
//
//   channel   handshake              payload
//   input     start / busy           in_mode, in_entry_index, in_key_0..3,
//                                    in_code_value, in_code_length
//   result    out_valid (strobe)     out_packed_word, out_bits_used, out_last
//   config    cfg_write_en           cfg_write_data (patch_len)
//
// A load or a flush beat leaves busy low; a flush word appears in the cycle
// after it is accepted. An encode beat holds busy while the search reads
// one codebook row per cycle from the single table read port, over at most
// min(TABLE_ENTRIES, 256) rows, and stops at the first hit.
// Reset clears the valid flags, the pending word and patch_len (to 1).
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module huffman_codebook_bit_packer #(
  parameter int TABLE_ENTRIES   = hcbp_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_PATCH_WORDS = hcbp_pkg::MAX_PATCH_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_mode,
  input  logic [hcbp_pkg::ENTRY_W-1:0]     in_entry_index,
  input  logic [hcbp_pkg::KEY_W-1:0]       in_key_0,
  input  logic [hcbp_pkg::KEY_W-1:0]       in_key_1,
  input  logic [hcbp_pkg::KEY_W-1:0]       in_key_2,
  input  logic [hcbp_pkg::KEY_W-1:0]       in_key_3,
  input  logic [hcbp_pkg::WORD_BITS-1:0]   in_code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]       in_code_length,
  output logic                             out_valid,
  output logic [hcbp_pkg::WORD_BITS-1:0]   out_packed_word,
  output logic [hcbp_pkg::LEN_W-1:0]       out_bits_used,
  output logic                             out_last,
  input  logic                             cfg_write_en,
  input  logic [hcbp_pkg::PLEN_W-1:0]      cfg_write_data
);
  import hcbp_pkg::*;

  // Only entry indexes below 256 can ever be loaded.
  localparam int ENTRIES_USED = (TABLE_ENTRIES < (1 << ENTRY_W)) ? TABLE_ENTRIES
                                                                 : (1 << ENTRY_W);
  localparam int IDX_W  = $clog2(ENTRIES_USED);
  localparam int KEYS_W = MAX_PATCH_WORDS * KEY_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_r, state_nxt;
  logic [IDX_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [KEYS_W-1:0]   key_r;
  logic [PLEN_W-1:0]   patch_len_r;

  logic                accept;
  logic [4*KEY_W-1:0]  in_keys_all;
  logic [LEN_W-1:0]    len_sat;
  logic                wr_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                rd_valid;
  logic [KEYS_W-1:0]   rd_keys;
  logic [WORD_BITS-1:0] rd_code;
  logic [LEN_W-1:0]    rd_len;
  logic [PLEN_W-1:0]   n_words;
  logic [MAX_PATCH_WORDS-1:0] word_ok;
  logic                hit;
  logic                scan_last;
  pack_req_t           req;

  assign accept      = start && !busy;
  assign busy        = (state_r == ST_SCAN);
  assign in_keys_all = {in_key_3, in_key_2, in_key_1, in_key_0};
  assign len_sat     = (in_code_length > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS)
                                                            : in_code_length;
  assign wr_en       = accept && (in_mode == MODE_LOAD) &&
                       ({1'b0, in_entry_index} < (ENTRY_W+1)'(ENTRIES_USED));
  assign scan_last   = (scan_idx_r == IDX_W'(ENTRIES_USED - 1));

  always_comb begin
    if (state_r == ST_SCAN && !scan_last) begin
      rd_addr = scan_idx_r + IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    if (patch_len_r == '0) begin
      n_words = PLEN_W'(1);
    end else if (patch_len_r > PLEN_W'(MAX_PATCH_WORDS)) begin
      n_words = PLEN_W'(MAX_PATCH_WORDS);
    end else begin
      n_words = patch_len_r;
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_PATCH_WORDS; w++) begin
      word_ok[w] = (PLEN_W'(w) >= n_words) ||
                   (rd_keys[w*KEY_W +: KEY_W] == key_r[w*KEY_W +: KEY_W]);
    end
    hit = (state_r == ST_SCAN) && rd_valid && (&word_ok);
  end

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode == MODE_ENCODE) begin
          state_nxt    = ST_SCAN;
          scan_idx_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (hit || scan_last) begin
          state_nxt = ST_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req.append = hit;
    req.flush  = accept && (in_mode == MODE_FLUSH);
    req.code   = rd_code;
    req.len    = rd_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      patch_len_r <= PLEN_W'(1);
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      if (cfg_write_en) begin
        patch_len_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_keys_all[KEYS_W-1:0];
    end
  end

  hcbp_table #(
    .ENTRIES         (ENTRIES_USED),
    .MAX_PATCH_WORDS (MAX_PATCH_WORDS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (in_entry_index[IDX_W-1:0]),
    .wr_keys  (in_keys_all[KEYS_W-1:0]),
    .wr_code  (in_code_value & low_mask(len_sat)),
    .wr_len   (len_sat),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_keys  (rd_keys),
    .rd_code  (rd_code),
    .rd_len   (rd_len)
  );

  hcbp_packer u_packer (
    .clk             (clk),
    .rst_n           (rst_n),
    .req             (req),
    .out_valid       (out_valid),
    .out_packed_word (out_packed_word),
    .out_bits_used   (out_bits_used),
    .out_last        (out_last)
  );

endmodule

>>> rtl/core/hcbp_checker.sv
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks of the Huffman codebook bit packer, bound to the top.
// ----------------------------------------------------------------------------
module hcbp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [1:0]                   in_mode,
  input logic                         out_valid,
  input logic [hcbp_pkg::LEN_W-1:0]   out_bits_used,
  input logic                         out_last
);
  import hcbp_pkg::*;

  // A flush beat yields a last word in the next cycle.
  a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_FLUSH) |=> (out_valid && out_last))
    else $error("flush beat did not produce a last word");

  // An encode beat always starts a table search.
  a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_ENCODE) |=> busy)
    else $error("encode beat did not raise busy");

  // Words that are not last are always full.
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_bits_used == LEN_W'(WORD_BITS)))
    else $error("non-last word is not full");

  // Full words only come out of a search.
  a_word_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> $past(busy))
    else $error("full word without a preceding search");

endmodule

bind huffman_codebook_bit_packer hcbp_checker u_hcbp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_mode       (in_mode),
  .out_valid     (out_valid),
  .out_bits_used (out_bits_used),
  .out_last      (out_last)
);
